// ===== rtl/pas_pkg.sv =====
// pas_pkg: shared types, constants and score helpers for the priority aging scheduler
// no dependencies; used by pas_ctrl, pas_datapath and priority_aging_scheduler_top
`default_nettype none

package pas_pkg;

    localparam int PRIO_W     = 4;
    localparam int AGE_W      = 8;
    localparam int WEIGHT_W   = 3;
    localparam int SCORE_W    = 9;
    localparam int ACTION_W   = 2;
    localparam int PID_W      = 6;
    localparam int OUT_SLOT_W = 5;
    localparam int CODE_W     = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 3'd3;
    localparam logic [AGE_W-1:0]    AGE_MAX      = 8'hFF;

    typedef enum logic [1:0] {
        TS_READY = 2'd0,
        TS_RUN   = 2'd1,
        TS_TERM  = 2'd2
    } task_state_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_EXIT   = 2'd1,
        ACT_CREATE = 2'd2,
        ACT_KILL   = 2'd3
    } action_t;

    typedef enum logic [CODE_W-1:0] {
        RC_OK        = 2'd0,
        RC_NOT_FOUND = 2'd1,
        RC_FULL      = 2'd2
    } result_code_t;

    typedef struct packed {
        task_state_t        state;
        logic [PRIO_W-1:0]  prio;
        logic [AGE_W-1:0]   age;
    } entry_t;

    localparam entry_t ENTRY0_RESET = '{state: TS_RUN, prio: 4'd2, age: 8'd0};

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic load;
        logic scan;
        logic fix_old;
        logic fix_new;
        logic finish;
    } pas_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic early_out;
        logic scan_path;
        logic scan_done;
        logic out_free;
    } pas_sts_t;

    function automatic logic [SCORE_W-1:0] score_of(entry_t e, logic [WEIGHT_W-1:0] w);
        logic [PRIO_W+WEIGHT_W-1:0] prod;
        prod = e.prio * w;
        return SCORE_W'(prod) + SCORE_W'(e.age);
    endfunction

    function automatic logic [AGE_W-1:0] age_inc(logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? a : a + AGE_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pas_ctrl.sv =====
// pas_ctrl: sequencing state machine of the priority aging scheduler
// depends on pas_pkg for command and status structs
`default_nettype none

module pas_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire pas_pkg::pas_sts_t sts,
    output pas_pkg::pas_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECODE  = 7'b0000010,
        ST_LOAD    = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_FIX_OLD = 7'b0010000,
        ST_FIX_NEW = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = sts.early_out ? ST_FINISH : ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = sts.scan_path ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_FIX_OLD;
                end
            end
            ST_FIX_OLD:
            begin
                cmd.fix_old = 1'b1;
                state_next  = ST_FIX_NEW;
            end
            ST_FIX_NEW:
            begin
                cmd.fix_new = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pas_datapath.sv =====
// pas_datapath: task table memory, scan unit, running task registers and result register
// depends on pas_pkg; driven by pas_ctrl through pas_cmd_t
`default_nettype none

module pas_datapath #(
    parameter int MAX_TASKS = 32,
    localparam int SLOT_W   = $clog2(MAX_TASKS),
    localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pas_pkg::WEIGHT_W-1:0]      cfg_wdata,
    input  wire logic [pas_pkg::ACTION_W-1:0]      in_action,
    input  wire logic [pas_pkg::PID_W-1:0]         in_pid,
    input  wire pas_pkg::pas_cmd_t                 cmd,
    output pas_pkg::pas_sts_t                      sts,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic                                   out_switched,
    output logic [pas_pkg::OUT_SLOT_W-1:0]         out_prev_slot,
    output logic [pas_pkg::OUT_SLOT_W-1:0]         out_next_slot,
    output logic                                   out_running_valid,
    output logic [pas_pkg::CODE_W-1:0]             out_code,
    output logic [pas_pkg::PID_W-1:0]              out_new_pid
);

    // task table
    pas_pkg::entry_t mem [MAX_TASKS];
    pas_pkg::entry_t rd_data_reg;
    logic [SLOT_W-1:0] rd_addr_reg;
    logic              slot0_written_reg;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    pas_pkg::entry_t   wr_data;
    pas_pkg::entry_t   rd_eff;

    // scheduler state
    logic [pas_pkg::WEIGHT_W-1:0] weight_reg;
    logic [CNT_W-1:0]             used_count_reg;
    logic [SLOT_W-1:0]            running_slot_reg;
    logic                         running_flag_reg;

    // per request
    pas_pkg::action_t             action_reg;
    logic [pas_pkg::PID_W-1:0]    pid_reg;
    logic [SLOT_W-1:0]            prev_slot_reg;
    logic                         prev_flag_reg;
    pas_pkg::entry_t              held_reg;
    pas_pkg::result_code_t        code_reg;
    logic [pas_pkg::PID_W-1:0]    new_pid_reg;
    logic                         dispatch_reg;

    // scan unit
    logic [CNT_W-1:0]             idx_reg;
    logic                         pend_reg;
    logic                         best_found_reg;
    logic [SLOT_W-1:0]            best_slot_reg;
    logic [pas_pkg::SCORE_W-1:0]  best_score_reg;
    logic [pas_pkg::PRIO_W-1:0]   best_prio_reg;

    // result register
    logic                         out_valid_reg;
    logic                         out_switched_reg;
    logic [pas_pkg::OUT_SLOT_W-1:0] out_prev_reg;
    logic [pas_pkg::OUT_SLOT_W-1:0] out_next_reg;
    logic                         out_run_reg;
    logic [pas_pkg::CODE_W-1:0]   out_code_reg;
    logic [pas_pkg::PID_W-1:0]    out_new_pid_reg;

    logic [SLOT_W-1:0]            kill_slot;
    logic                         kill_hit;
    logic                         pid_bad;
    logic                         table_full;
    logic                         exit_path;
    logic [pas_pkg::SCORE_W-1:0]  run_score;
    logic [pas_pkg::SCORE_W-1:0]  scan_score;
    logic                         scan_cand;
    logic                         scan_better;
    logic                         best_better;
    logic                         preempt;
    logic                         dispatch;
    logic                         scan_issue;

    assign rd_eff = (rd_addr_reg == '0 && !slot0_written_reg) ? pas_pkg::ENTRY0_RESET
                                                              : rd_data_reg;

    assign kill_slot  = SLOT_W'(pid_reg - pas_pkg::PID_W'(1));
    assign kill_hit   = running_flag_reg && (kill_slot == running_slot_reg);
    assign pid_bad    = (pid_reg == '0) || (8'(pid_reg) > 8'(used_count_reg));
    assign table_full = (used_count_reg >= CNT_W'(MAX_TASKS));
    assign exit_path  = (action_reg == pas_pkg::ACT_EXIT) ||
                        (action_reg == pas_pkg::ACT_KILL && kill_hit);

    assign run_score   = pas_pkg::score_of(held_reg, weight_reg);
    assign best_better = best_score_reg > run_score;
    assign preempt     = (action_reg == pas_pkg::ACT_TICK) && running_flag_reg &&
                         best_found_reg && best_better;
    assign dispatch    = best_found_reg &&
                         (((action_reg == pas_pkg::ACT_TICK) &&
                           (!running_flag_reg || best_better)) ||
                          (exit_path && running_flag_reg));

    assign scan_score  = pas_pkg::score_of(rd_eff, weight_reg);
    assign scan_cand   = pend_reg && (rd_eff.state == pas_pkg::TS_READY);
    assign scan_better = !best_found_reg || (scan_score > best_score_reg);
    assign scan_issue  = cmd.scan && (idx_reg < used_count_reg);

    always_comb
    begin
        sts.early_out = ((action_reg == pas_pkg::ACT_CREATE) && table_full) ||
                        ((action_reg == pas_pkg::ACT_KILL) && pid_bad);
        sts.scan_path = (action_reg == pas_pkg::ACT_TICK) ||
                        (action_reg == pas_pkg::ACT_EXIT) ||
                        ((action_reg == pas_pkg::ACT_KILL) && kill_hit);
        sts.scan_done = (idx_reg == used_count_reg) && !pend_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // read port: held entry on decode, table walk on scan
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = running_slot_reg;
        if (cmd.decode)
        begin
            rd_en   = !sts.early_out;
            rd_addr = (action_reg == pas_pkg::ACT_KILL) ? kill_slot : running_slot_reg;
        end
        else if (scan_issue)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg[SLOT_W-1:0];
        end
    end

    // write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = running_slot_reg;
        wr_data = held_reg;
        if (cmd.load && action_reg == pas_pkg::ACT_CREATE)
        begin
            wr_en   = 1'b1;
            wr_addr = SLOT_W'(used_count_reg);
            wr_data = '{state: pas_pkg::TS_READY, prio: rd_eff.prio, age: rd_eff.age};
        end
        else if (cmd.load && action_reg == pas_pkg::ACT_KILL && !kill_hit &&
                 rd_eff.state == pas_pkg::TS_READY)
        begin
            wr_en   = 1'b1;
            wr_addr = kill_slot;
            wr_data = '{state: pas_pkg::TS_TERM, prio: rd_eff.prio, age: rd_eff.age};
        end
        else if (scan_cand)
        begin
            // aging during the walk; decisions use the score before aging
            wr_en   = 1'b1;
            wr_addr = rd_addr_reg;
            wr_data = '{state: pas_pkg::TS_READY, prio: rd_eff.prio,
                        age: pas_pkg::age_inc(rd_eff.age)};
        end
        else if (cmd.fix_old && preempt)
        begin
            wr_en   = 1'b1;
            wr_addr = running_slot_reg;
            wr_data = '{state: pas_pkg::TS_READY, prio: held_reg.prio,
                        age: pas_pkg::age_inc(held_reg.age)};
        end
        else if (cmd.fix_old && exit_path && running_flag_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = running_slot_reg;
            wr_data = '{state: pas_pkg::TS_TERM, prio: held_reg.prio, age: held_reg.age};
        end
        else if (cmd.fix_new && dispatch_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = best_slot_reg;
            wr_data = '{state: pas_pkg::TS_RUN, prio: best_prio_reg, age: '0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg    <= pas_pkg::action_t'(in_action);
            pid_reg       <= in_pid;
            prev_slot_reg <= running_slot_reg;
            prev_flag_reg <= running_flag_reg;
        end
        if (cmd.load)
        begin
            held_reg <= rd_eff;
        end
        if (cmd.fix_old)
        begin
            dispatch_reg <= dispatch;
        end
        if (scan_cand && scan_better)
        begin
            best_slot_reg  <= rd_addr_reg;
            best_score_reg <= scan_score;
            best_prio_reg  <= rd_eff.prio;
        end
        if (cmd.finish)
        begin
            out_switched_reg <= (prev_flag_reg != running_flag_reg) ||
                                (prev_slot_reg != running_slot_reg);
            out_prev_reg     <= pas_pkg::OUT_SLOT_W'(prev_slot_reg);
            out_next_reg     <= pas_pkg::OUT_SLOT_W'(running_slot_reg);
            out_run_reg      <= running_flag_reg;
            out_code_reg     <= code_reg;
            out_new_pid_reg  <= new_pid_reg;
        end
    end

    // control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg        <= pas_pkg::WEIGHT_RESET;
            used_count_reg    <= CNT_W'(1);
            running_slot_reg  <= '0;
            running_flag_reg  <= 1'b1;
            slot0_written_reg <= 1'b0;
            code_reg          <= pas_pkg::RC_OK;
            new_pid_reg       <= '0;
            idx_reg           <= '0;
            pend_reg          <= 1'b0;
            best_found_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                weight_reg <= cfg_wdata;
            end
            if (wr_en && wr_addr == '0)
            begin
                slot0_written_reg <= 1'b1;
            end
            if (cmd.capture)
            begin
                code_reg    <= pas_pkg::RC_OK;
                new_pid_reg <= '0;
            end
            if (cmd.decode && sts.early_out)
            begin
                code_reg <= (action_reg == pas_pkg::ACT_CREATE) ? pas_pkg::RC_FULL
                                                                : pas_pkg::RC_NOT_FOUND;
            end
            if (cmd.load)
            begin
                idx_reg        <= '0;
                pend_reg       <= 1'b0;
                best_found_reg <= 1'b0;
                if (action_reg == pas_pkg::ACT_CREATE)
                begin
                    used_count_reg <= used_count_reg + CNT_W'(1);
                    new_pid_reg    <= pas_pkg::PID_W'(used_count_reg + CNT_W'(1));
                end
            end
            if (cmd.scan)
            begin
                pend_reg <= scan_issue;
                if (scan_issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            if (scan_cand)
            begin
                best_found_reg <= 1'b1;
            end
            if (cmd.fix_old && exit_path && running_flag_reg)
            begin
                running_flag_reg <= 1'b0;
            end
            if (cmd.fix_new && dispatch_reg)
            begin
                running_slot_reg <= best_slot_reg;
                running_flag_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_switched      = out_switched_reg;
    assign out_prev_slot     = out_prev_reg;
    assign out_next_slot     = out_next_reg;
    assign out_running_valid = out_run_reg;
    assign out_code          = out_code_reg;
    assign out_new_pid       = out_new_pid_reg;

endmodule

`default_nettype wire

// ===== rtl/priority_aging_scheduler_top.sv =====
// tick, exit and kill of the running task run decode, load, a scan of the used slots,
// fix_old, fix_new and finish; create and kill of a ready task run decode, load, finish;
// rejects run decode and finish. One request at a time: the next is taken once the
// controller is back in idle, and a result still held by the receiver stalls the finish
// step; the table walk reads one entry per cycle through the single memory read port
// reset: slot 0 running with priority 2, one used slot, weight 3; no clearing pass
`default_nettype none

module priority_aging_scheduler_top #(
    parameter int MAX_TASKS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // weight register write
    input  wire logic                              cfg_we,
    input  wire logic [pas_pkg::WEIGHT_W-1:0]      cfg_wdata,
    // request side
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [pas_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // target_pid[5:0], zero pad
    input  wire logic [pas_pkg::ACTION_W-1:0]      s_axis_tuser,  // action[1:0]
    // result side
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // switched[0], prev_slot[5:1], next_slot[10:6], running_valid[11],
    // status_code[13:12], new_pid[19:14], zero pad[23:20]
    output logic [pas_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    pas_pkg::pas_cmd_t cmd;
    pas_pkg::pas_sts_t sts;

    logic                               res_switched;
    logic [pas_pkg::OUT_SLOT_W-1:0]     res_prev_slot;
    logic [pas_pkg::OUT_SLOT_W-1:0]     res_next_slot;
    logic                               res_running_valid;
    logic [pas_pkg::CODE_W-1:0]         res_code;
    logic [pas_pkg::PID_W-1:0]          res_new_pid;

    // sequencer: one request in flight, result register decouples the output side
    pas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // task table, best ready search with aging, running task state
    pas_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_action         (s_axis_tuser),
        .in_pid            (s_axis_tdata[pas_pkg::PID_W-1:0]),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_switched      (res_switched),
        .out_prev_slot     (res_prev_slot),
        .out_next_slot     (res_next_slot),
        .out_running_valid (res_running_valid),
        .out_code          (res_code),
        .out_new_pid       (res_new_pid)
    );

    // pack result fields from the lowest bit up
    assign m_axis_tdata = {4'b0, res_new_pid, res_code, res_running_valid,
                           res_next_slot, res_prev_slot, res_switched};

endmodule

`default_nettype wire

// ===== tb/sv/pas_sched_checker.sv =====
// pas_sched_checker: watches the request, result and weight write channels of the scheduler,
// keeps its own copy of the task table and compares every result with the expected one
// depends on pas_pkg for field widths and codes
`default_nettype none

module pas_sched_checker #(
    parameter int MAX_TASKS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pas_pkg::WEIGHT_W-1:0]      cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic [pas_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic [pas_pkg::ACTION_W-1:0]      s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [pas_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output int                                     err_count,
    output int                                     pending_count,
    output int                                     checked_count,
    output int                                     switch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pas_pkg::*;

    // result word, lowest field last
    typedef struct packed {
        logic [3:0]            pad;
        logic [PID_W-1:0]      new_pid;
        result_code_t          code;
        logic                  running_valid;
        logic [OUT_SLOT_W-1:0] next_slot;
        logic [OUT_SLOT_W-1:0] prev_slot;
        logic                  switched;
    } sched_result_t;

    // shadow task table
    task_state_t          ent_state [MAX_TASKS];
    logic [PRIO_W-1:0]    ent_prio  [MAX_TASKS];
    logic [AGE_W-1:0]     ent_age   [MAX_TASKS];
    int                   used_slots;
    int                   run_slot;
    logic                 run_flag;
    logic [WEIGHT_W-1:0]  weight;

    sched_result_t        expected_results[$];
    sched_result_t        got;
    sched_result_t        want;
    int                   errs;
    int                   checked;
    int                   switches;

    function automatic int task_score(int s);
        return int'(ent_prio[s]) * int'(weight) + int'(ent_age[s]);
    endfunction

    // highest score among used ready slots, lowest index on ties, -1 if none
    function automatic int pick_best_ready();
        int best;
        int best_sc;
        best = -1;
        best_sc = 0;
        for (int i = 0; i < used_slots; i++) begin
            if (ent_state[i] == TS_READY && (best < 0 || task_score(i) > best_sc)) begin
                best = i;
                best_sc = task_score(i);
            end
        end
        return best;
    endfunction

    function automatic void dispatch_slot(int s);
        ent_state[s] = TS_RUN;
        ent_age[s] = '0;
        run_slot = s;
        run_flag = 1'b1;
    endfunction

    function automatic void age_ready_tasks();
        for (int i = 0; i < used_slots; i++) begin
            if (ent_state[i] == TS_READY && ent_age[i] != AGE_MAX)
                ent_age[i] = ent_age[i] + 1'b1;
        end
    endfunction

    // exit path: retire the running task, hand over, then age
    function automatic void retire_running();
        int best;
        if (run_flag) begin
            ent_state[run_slot] = TS_TERM;
            run_flag = 1'b0;
            best = pick_best_ready();
            if (best >= 0)
                dispatch_slot(best);
        end
        age_ready_tasks();
    endfunction

    function automatic sched_result_t predict_request(action_t act, logic [PID_W-1:0] pid);
        sched_result_t r;
        int prev_slot_v;
        logic prev_flag;
        int best;
        int victim;
        r = '0;
        prev_slot_v = run_slot;
        prev_flag = run_flag;
        r.code = RC_OK;
        case (act)
            ACT_TICK:
            begin
                best = pick_best_ready();
                if (best >= 0) begin
                    if (!run_flag) begin
                        dispatch_slot(best);
                    end else if (task_score(best) > task_score(run_slot)) begin
                        ent_state[run_slot] = TS_READY;
                        dispatch_slot(best);
                    end
                end
                age_ready_tasks();
            end
            ACT_EXIT:
            begin
                retire_running();
            end
            ACT_CREATE:
            begin
                if (used_slots >= MAX_TASKS) begin
                    r.code = RC_FULL;
                end else begin
                    ent_state[used_slots] = TS_READY;
                    ent_prio[used_slots] = ent_prio[run_slot];
                    ent_age[used_slots] = ent_age[run_slot];
                    used_slots++;
                    r.new_pid = PID_W'(used_slots);
                end
            end
            default:
            begin
                if (pid == '0 || int'(pid) > used_slots) begin
                    r.code = RC_NOT_FOUND;
                end else begin
                    victim = int'(pid) - 1;
                    if (ent_state[victim] == TS_RUN && run_flag && victim == run_slot)
                        retire_running();
                    else if (ent_state[victim] == TS_READY)
                        ent_state[victim] = TS_TERM;
                end
            end
        endcase
        r.switched = (prev_flag != run_flag) || (prev_slot_v != run_slot);
        r.prev_slot = OUT_SLOT_W'(prev_slot_v);
        r.next_slot = OUT_SLOT_W'(run_slot);
        r.running_valid = run_flag;
        return r;
    endfunction

    function automatic void check_field(string what, int exp_v, int act_v);
        if (exp_v != act_v) begin
            errs++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                ent_state[i] = TS_READY;
                ent_prio[i] = '0;
                ent_age[i] = '0;
            end
            ent_state[0] = TS_RUN;
            ent_prio[0] = PRIO_W'(2);
            used_slots = 1;
            run_slot = 0;
            run_flag = 1'b1;
            weight = WEIGHT_RESET;
            expected_results.delete();
            errs = 0;
            checked = 0;
            switches = 0;
        end else begin
            if (cfg_we)
                weight = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(
                    predict_request(action_t'(s_axis_tuser), s_axis_tdata[PID_W-1:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = sched_result_t'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    errs++;
                    $display("%0t: result with no request waiting, got %h", $time, m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.switched)
                        switches++;
                    check_field("switched", want.switched, got.switched);
                    check_field("prev_slot", want.prev_slot, got.prev_slot);
                    check_field("next_slot", want.next_slot, got.next_slot);
                    check_field("running_valid", want.running_valid, got.running_valid);
                    check_field("status_code", want.code, got.code);
                    check_field("new_pid", want.new_pid, got.new_pid);
                    check_field("pad", want.pad, got.pad);
                end
            end
        end
        err_count <= errs;
        pending_count <= expected_results.size();
        checked_count <= checked;
        switch_count <= switches;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_priority_aging_scheduler_top.sv =====
// tb_priority_aging_scheduler_top: clock, reset and request stimulus for the scheduler,
// with a stalling result receiver; checking is done by pas_sched_checker
// depends on pas_pkg, priority_aging_scheduler_top and pas_sched_checker
`default_nettype none

module tb_priority_aging_scheduler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pas_pkg::*;

    localparam int MAX_TASKS     = 32;
    localparam int CYCLE_LIMIT   = 400000;
    // long receiver hold-off, enough to back the block up into its input
    localparam int HOLD_CYCLES   = 300;
    // settle time covers the longest request path, a scan of all slots plus the other steps
    localparam int SETTLE_CYCLES = MAX_TASKS + 16;
    localparam int SAT_EXITS     = 260;
    localparam int BLOCK_ITEMS   = 43;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [WEIGHT_W-1:0]    cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;    // target_pid[5:0], zero pad[7:6]
    logic [ACTION_W-1:0]    s_axis_tuser = '0;    // action[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // switched[0], prev_slot[5:1], next_slot[10:6], running_valid[11],
    // status_code[13:12], new_pid[19:14], zero pad[23:20]
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    int err_count;
    int pending_count;
    int checked_count;
    int switch_count;

    // stimulus bookkeeping
    int sent_count = 0;
    int weight_writes = 0;
    int cycle_cnt = 0;

    // receiver control: hold_req is raised once by the stimulus, the receiver counts the stall
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;

    always #4 clk = ~clk;

    priority_aging_scheduler_top #(
        .MAX_TASKS(MAX_TASKS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    pas_sched_checker #(
        .MAX_TASKS(MAX_TASKS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .err_count(err_count),
        .pending_count(pending_count),
        .checked_count(checked_count),
        .switch_count(switch_count)
    );

    // result receiver: one long hold-off when asked, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(32, 200);
            end
            else
            begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;                          // no stalls
                1: m_axis_tready <= 1'($urandom_range(0, 1));      // coin flip
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
            endcase
        end
    end

    // watchdog
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // offer one request and hold it until the block takes it
    task automatic send_request(action_t act, logic [PID_W-1:0] pid);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= IN_DATA_W'(pid);
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
    endtask

    // sender gap; a zero gap keeps valid high into the next request
    task automatic idle_sender(int n);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // request followed now and then by a short gap
    task automatic paced_request(action_t act, logic [PID_W-1:0] pid);
        send_request(act, pid);
        if ($urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 6));
    endtask

    // stop the sender, let every result come back and the block settle, then set the weight
    task automatic drain_and_set_weight(logic [WEIGHT_W-1:0] w);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        weight_writes++;
    endtask

    // tick heavy mix, kill pids cover the empty pid, live slots and slots not yet created
    task automatic random_request();
        int pick;
        action_t act;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            act = ACT_TICK;
        else if (pick < 62)
            act = ACT_CREATE;
        else if (pick < 70)
            act = ACT_EXIT;
        else
            act = ACT_KILL;
        send_request(act, PID_W'($urandom_range(0, MAX_TASKS)));
    endtask

    // bursts of random length, gaps of random length, some back-to-back stretches
    task automatic random_block(int n);
        int done_items;
        int burst;
        done_items = 0;
        while (done_items < n)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && done_items < n; i++)
            begin
                random_request();
                done_items++;
            end
            if ($urandom_range(0, 9) >= 3)
                idle_sender($urandom_range(1, 20));
        end
    endtask

    initial
    begin
        logic [WEIGHT_W-1:0] blk_weight;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset weight
        paced_request(ACT_TICK, 6'd0);          // nothing ready, no switch
        paced_request(ACT_KILL, 6'd0);          // pid zero is never valid
        paced_request(ACT_KILL, 6'd32);         // pid beyond the used slots
        paced_request(ACT_CREATE, 6'd63);       // clone of slot 0
        paced_request(ACT_CREATE, 6'd21);
        paced_request(ACT_TICK, 6'd0);          // equal scores, running task keeps the cpu
        paced_request(ACT_TICK, 6'd0);          // aged ready tasks tie, lower slot preempts
        paced_request(ACT_KILL, 6'd3);          // kill a ready task
        paced_request(ACT_KILL, 6'd3);          // kill it again, already terminated
        paced_request(ACT_KILL, 6'd2);          // kill the running task goes the exit path
        paced_request(ACT_KILL, 6'd4);          // pid just past the used slots
        paced_request(ACT_EXIT, 6'd0);          // exit with nothing ready left, cpu idles
        paced_request(ACT_TICK, 6'd0);          // idle cpu and nothing ready
        paced_request(ACT_EXIT, 6'd0);          // exit with nothing running
        paced_request(ACT_CREATE, 6'd0);        // clone while nothing runs
        paced_request(ACT_TICK, 6'd0);          // idle cpu picks up the new task
        paced_request(ACT_KILL, 6'd1);          // terminated slot 0

        // zero weight: idle the cpu with one ready task, then exits age it into saturation
        drain_and_set_weight(3'd0);
        paced_request(ACT_EXIT, 6'd0);
        paced_request(ACT_CREATE, 6'd0);
        for (int i = 0; i < SAT_EXITS; i++)
            paced_request(ACT_EXIT, PID_W'($urandom_range(0, MAX_TASKS)));
        paced_request(ACT_TICK, 6'd0);

        // random blocks over several weights, full scale first
        for (int blk = 0; blk < 4; blk++)
        begin
            case (blk)
                0: blk_weight = 3'd7;
                1: blk_weight = WEIGHT_W'($urandom_range(1, 6));
                2: blk_weight = 3'd0;
                default: blk_weight = WEIGHT_W'($urandom_range(0, 7));
            endcase
            drain_and_set_weight(blk_weight);
            // long receiver hold-off while the sender keeps pushing
            if (blk == 1)
                hold_req <= 1'b1;
            random_block(BLOCK_ITEMS);
        end

        // wait for the tail, then a little longer for anything unexpected
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d requests over %0d weight settings, incl. an age saturation run",
                 sent_count, weight_writes + 1);
        $display("%0d results compared, %0d of them switched the running task",
                 checked_count, switch_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
